// ===== sv/two_pattern_max_span_search_defines.svh =====
// ----------------------------------------------------------------------------
// two_pattern_max_span_search_defines
// assertion macros shared by the span search block
// ----------------------------------------------------------------------------
`ifndef TWO_PATTERN_MAX_SPAN_SEARCH_DEFINES_SVH
`define TWO_PATTERN_MAX_SPAN_SEARCH_DEFINES_SVH

// condition holds in the same cycle
`define TPMS_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tpms assertion failed");

// condition holds in the next cycle
`define TPMS_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tpms assertion failed");

`endif

// ===== sv/tpms_pkg.sv =====
// ----------------------------------------------------------------------------
// tpms_pkg
// types and constants of the two-pattern span search
// ----------------------------------------------------------------------------
package tpms_pkg;

    localparam int BYTE_W    = 8;
    localparam int PAT_BYTES = 10;
    localparam int LEN_W     = 4;
    localparam int HIGH_W    = 16;
    localparam int LOW_W     = 64;
    localparam int SPAN_W    = 11;
    localparam int DATA_W    = 64;
    localparam int ADDR_W    = 6;

    localparam logic [SPAN_W-1:0] SPAN_NONE = '1;

    typedef enum logic [2:0] {
        REG_FIRST_LOW   = 3'd0,
        REG_FIRST_HIGH  = 3'd1,
        REG_FIRST_LEN   = 3'd2,
        REG_SECOND_LOW  = 3'd3,
        REG_SECOND_HIGH = 3'd4,
        REG_SECOND_LEN  = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [LOW_W-1:0]  first_low;
        logic [HIGH_W-1:0] first_high;
        logic [LEN_W-1:0]  first_len;
        logic [LOW_W-1:0]  second_low;
        logic [HIGH_W-1:0] second_high;
        logic [LEN_W-1:0]  second_len;
    } cfg_t;

    typedef struct packed {
        logic first;
        logic second;
    } hits_t;

    // byte k of a pattern, zero past the stored bytes
    function automatic logic [BYTE_W-1:0] pat_byte(
        input logic [LOW_W-1:0]  low,
        input logic [HIGH_W-1:0] high,
        input int unsigned       k
    );
        logic [BYTE_W-1:0] b;
        b = '0;
        if (k < 8)
        begin
            b = low[k*BYTE_W +: BYTE_W];
        end
        else if (k < PAT_BYTES)
        begin
            b = high[(k-8)*BYTE_W +: BYTE_W];
        end
        return b;
    endfunction

endpackage

// ===== sv/tpms_if.sv =====
// ----------------------------------------------------------------------------
// tpms_if
// text and result channels of the span search
// ----------------------------------------------------------------------------
interface tpms_text_if;
    import tpms_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] text_byte;
    logic              end_of_text;

    modport source (output valid, text_byte, end_of_text, input ready);
    modport sink (input valid, text_byte, end_of_text, output ready);
endinterface

interface tpms_result_if;
    import tpms_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [SPAN_W-1:0] span;
    logic                     pair_found;

    modport source (output valid, span, pair_found, input ready);
    modport sink (input valid, span, pair_found, output ready);
endinterface

// ===== sv/two_pattern_max_span_search.sv =====
// ----------------------------------------------------------------------------
// two_pattern_max_span_search
// span between the first pattern-one end and the last later pattern-two start
// ----------------------------------------------------------------------------
// Text bytes enter one per cycle unless a held result stalls them; an
// end_of_text beat yields a result beat in the next cycle from an output
// register, and a new text may follow at once if result.ready is high.
// A row of MAX_PATTERN cells keeps, per position, whether each pattern's
// prefix up to it ends at the latest byte. span is the number of characters
// between the two matches, or -1 with pair_found low. Bytes beyond MAX_TEXT
// in one text are not searched. Patterns and lengths sit at apb byte address
// 8*i; users must write them only while no text is in flight (not enforced).
module two_pattern_max_span_search #(
    parameter int MAX_TEXT    = 1024,
    parameter int MAX_PATTERN = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    tpms_text_if.sink                     text,
    tpms_result_if.source                 result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tpms_pkg::ADDR_W-1:0]   paddr,
    input  logic [tpms_pkg::DATA_W-1:0]   pwdata,
    output logic [tpms_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import tpms_pkg::*;

    `include "two_pattern_max_span_search_defines.svh"

    localparam int POS_W = $clog2(MAX_TEXT + 1);
    localparam int LW    = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int EW    = (POS_W > SPAN_W) ? POS_W : SPAN_W;

    cfg_t  cfg;
    hits_t hit_vec  [MAX_PATTERN];
    hits_t hold_vec [MAX_PATTERN];
    hits_t prev_vec [MAX_PATTERN];

    logic accept;
    logic advance;
    logic clear;

    logic [LW-1:0]    len1;
    logic [LW-1:0]    len2;
    logic [IDX_W-1:0] idx1;
    logic [IDX_W-1:0] idx2;
    logic             match1;
    logic             match2;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] first_end_reg, first_end_next;
    logic [POS_W-1:0] last_start_reg, last_start_next;
    logic             first_seen_reg, first_seen_next;
    logic             second_seen_reg, second_seen_next;

    logic             first_now;
    logic             first_seen_eff;
    logic [POS_W-1:0] first_end_eff;
    logic [POS_W-1:0] start;
    logic             second_now;
    logic             second_seen_eff;
    logic [POS_W-1:0] last_start_eff;
    logic [POS_W-1:0] diff;
    logic [EW-1:0]    diff_ext;
    logic             found;

    logic                     out_valid_reg, out_valid_next;
    logic signed [SPAN_W-1:0] span_reg, span_next;
    logic                     found_reg, found_next;

    tpms_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign text.ready = !out_valid_reg || result.ready;
    assign accept     = text.valid && text.ready;
    assign advance    = accept && (pos_reg < POS_W'(MAX_TEXT));
    assign clear      = accept && text.end_of_text;

    genvar k;
    generate
        for (k = 0; k < MAX_PATTERN; k++)
        begin : g_cell
            if (k == 0)
            begin : g_head
                assign prev_vec[k] = '1;
            end
            else
            begin : g_link
                assign prev_vec[k] = hold_vec[k-1];
            end

            tpms_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .advance     (advance),
                .clear       (clear),
                .text_byte   (text.text_byte),
                .first_byte  (pat_byte(cfg.first_low, cfg.first_high, k)),
                .second_byte (pat_byte(cfg.second_low, cfg.second_high, k)),
                .prev        (prev_vec[k]),
                .hit         (hit_vec[k]),
                .hold        (hold_vec[k])
            );
        end
    endgenerate

    // length zero acts as one, longer than the chain acts as the chain
    always_comb
    begin
        if (cfg.first_len == '0)
        begin
            len1 = LW'(1);
        end
        else if (32'(cfg.first_len) > 32'(MAX_PATTERN))
        begin
            len1 = LW'(MAX_PATTERN);
        end
        else
        begin
            len1 = LW'(cfg.first_len);
        end

        if (cfg.second_len == '0)
        begin
            len2 = LW'(1);
        end
        else if (32'(cfg.second_len) > 32'(MAX_PATTERN))
        begin
            len2 = LW'(MAX_PATTERN);
        end
        else
        begin
            len2 = LW'(cfg.second_len);
        end
    end

    assign idx1   = IDX_W'(len1 - LW'(1));
    assign idx2   = IDX_W'(len2 - LW'(1));
    assign match1 = hit_vec[idx1].first;
    assign match2 = hit_vec[idx2].second;

    always_comb
    begin
        first_now       = advance && !first_seen_reg && match1;
        first_seen_eff  = first_seen_reg || first_now;
        first_end_eff   = first_now ? pos_reg : first_end_reg;
        start           = pos_reg + POS_W'(1) - POS_W'(len2);
        second_now      = advance && first_seen_eff && match2 && (start > first_end_eff);
        second_seen_eff = second_seen_reg || second_now;
        last_start_eff  = second_now ? start : last_start_reg;
        diff            = last_start_eff - first_end_eff - POS_W'(1);
        diff_ext        = EW'(diff);
        found           = first_seen_eff && second_seen_eff;

        if (clear)
        begin
            pos_next         = '0;
            first_seen_next  = 1'b0;
            first_end_next   = '0;
            second_seen_next = 1'b0;
            last_start_next  = '0;
        end
        else if (advance)
        begin
            pos_next         = pos_reg + POS_W'(1);
            first_seen_next  = first_seen_eff;
            first_end_next   = first_end_eff;
            second_seen_next = second_seen_eff;
            last_start_next  = last_start_eff;
        end
        else
        begin
            pos_next         = pos_reg;
            first_seen_next  = first_seen_reg;
            first_end_next   = first_end_reg;
            second_seen_next = second_seen_reg;
            last_start_next  = last_start_reg;
        end

        out_valid_next = out_valid_reg && !result.ready;
        span_next      = span_reg;
        found_next     = found_reg;
        if (clear)
        begin
            out_valid_next = 1'b1;
            found_next     = found;
            span_next      = found ? diff_ext[SPAN_W-1:0] : SPAN_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= '0;
            first_seen_reg  <= 1'b0;
            first_end_reg   <= '0;
            second_seen_reg <= 1'b0;
            last_start_reg  <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            pos_reg         <= pos_next;
            first_seen_reg  <= first_seen_next;
            first_end_reg   <= first_end_next;
            second_seen_reg <= second_seen_next;
            last_start_reg  <= last_start_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        span_reg  <= span_next;
        found_reg <= found_next;
    end

    assign result.valid      = out_valid_reg;
    assign result.span       = span_reg;
    assign result.pair_found = found_reg;

    `TPMS_ASSERT_SAME(a_none_span, result.valid && !result.pair_found, result.span == SPAN_NONE)
    `TPMS_ASSERT_NEXT(a_end_clears, clear, pos_reg == '0 && !first_seen_reg && !second_seen_reg)
    `TPMS_ASSERT_SAME(a_order, second_seen_reg, first_seen_reg)
    `TPMS_ASSERT_SAME(a_after_first, second_seen_reg, last_start_reg > first_end_reg)

endmodule

// ===== sv/tpms_apb_regs.sv =====
// ----------------------------------------------------------------------------
// tpms_apb_regs
// pattern and length registers behind the apb port
// ----------------------------------------------------------------------------
module tpms_apb_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tpms_pkg::ADDR_W-1:0]   paddr,
    input  logic [tpms_pkg::DATA_W-1:0]   pwdata,
    output logic [tpms_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output tpms_pkg::cfg_t                cfg
);
    import tpms_pkg::*;

    // patterns clear, both lengths one
    localparam cfg_t CFG_RESET = '{first_len: LEN_W'(1), second_len: LEN_W'(1), default: '0};

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[ADDR_W-1:3]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_FIRST_LOW:   cfg_next.first_low   = pwdata[LOW_W-1:0];
                REG_FIRST_HIGH:  cfg_next.first_high  = pwdata[HIGH_W-1:0];
                REG_FIRST_LEN:   cfg_next.first_len   = pwdata[LEN_W-1:0];
                REG_SECOND_LOW:  cfg_next.second_low  = pwdata[LOW_W-1:0];
                REG_SECOND_HIGH: cfg_next.second_high = pwdata[HIGH_W-1:0];
                REG_SECOND_LEN:  cfg_next.second_len  = pwdata[LEN_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_FIRST_LOW:   prdata = DATA_W'(cfg_reg.first_low);
            REG_FIRST_HIGH:  prdata = DATA_W'(cfg_reg.first_high);
            REG_FIRST_LEN:   prdata = DATA_W'(cfg_reg.first_len);
            REG_SECOND_LOW:  prdata = DATA_W'(cfg_reg.second_low);
            REG_SECOND_HIGH: prdata = DATA_W'(cfg_reg.second_high);
            REG_SECOND_LEN:  prdata = DATA_W'(cfg_reg.second_len);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== sv/tpms_cell.sv =====
// ----------------------------------------------------------------------------
// tpms_cell
// one position of the prefix match chain for both patterns
// ----------------------------------------------------------------------------
module tpms_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        advance,
    input  logic                        clear,
    input  logic [tpms_pkg::BYTE_W-1:0] text_byte,
    input  logic [tpms_pkg::BYTE_W-1:0] first_byte,
    input  logic [tpms_pkg::BYTE_W-1:0] second_byte,
    input  tpms_pkg::hits_t             prev,
    output tpms_pkg::hits_t             hit,
    output tpms_pkg::hits_t             hold
);
    import tpms_pkg::*;

    hits_t hold_reg;
    hits_t hold_next;

    // prefix up to this cell ends at the incoming byte
    assign hit.first  = prev.first && (text_byte == first_byte);
    assign hit.second = prev.second && (text_byte == second_byte);
    assign hold       = hold_reg;

    always_comb
    begin
        hold_next = hold_reg;
        if (clear)
        begin
            hold_next = '0;
        end
        else if (advance)
        begin
            hold_next = hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg <= '0;
        end
        else
        begin
            hold_reg <= hold_next;
        end
    end

endmodule
